FILE: design/assert_macros.svh
// Assertion macros shared by the LZF decompressor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk_sig, rst_sig, pre, post) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |-> (post)) \
        else $error("lzf assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk_sig, rst_sig, pre, post) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
        else $error("lzf assertion failed: next-cycle implication");

`endif

FILE: design/lzf_pkg.sv
// Shared types and constants of the LZF stream decompressor.
`default_nettype none

package lzf_pkg;

    localparam logic [1:0] PH_CTRL = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_OFF  = 2'd3;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_LIMIT        = 2'd1;
    localparam logic [1:0] STAT_BEFORE_START = 2'd2;
    localparam logic [1:0] STAT_TRUNCATED    = 2'd3;

    localparam logic [7:0] LIT_CTRL_LIMIT = 8'd32;
    localparam logic [2:0] LONG_LEN_CODE  = 3'd7;
    localparam logic [8:0] LEN_BIAS       = 9'd2;
    localparam logic [8:0] LONG_LEN_BASE  = 9'd9;

    localparam int         APB_ADDR_W       = 3;
    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;
    localparam logic [31:0] LIMIT_RESET     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic accept;
        logic issue;
        logic consume;
        logic status_load;
        logic eos_pending;
    } lzf_cmd_t;

    typedef struct packed {
        logic copy_start;
        logic rd_valid;
        logic copy_left_nz;
        logic chunk_end;
        logic out_free;
    } lzf_stat_t;

endpackage

`default_nettype wire

FILE: design/lzf_stream_if.sv
// Request channel interfaces for compressed bytes and decoded words.
`default_nettype none

interface lzf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzf_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic [3:0]  out_count;
    logic        run_last;
    logic        stream_done;
    logic [1:0]  status;
    logic [31:0] total_length;

    modport source (output valid, output out_word, output out_count, output run_last,
                    output stream_done, output status, output total_length, input ready);
    modport sink (input valid, input out_word, input out_count, input run_last,
                  input stream_done, input status, input total_length, output ready);
endinterface

`default_nettype wire

FILE: design/lzf_ctrl.sv
// Controller state machine of the LZF decompressor.
`default_nettype none
`include "assert_macros.svh"

module lzf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              end_of_stream,
    output logic                   in_ready,
    input  wire lzf_pkg::lzf_stat_t stat,
    output lzf_pkg::lzf_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_COPY   = 2'd1;
    localparam logic [1:0] S_STATUS = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       eos_pending_reg;
    logic       eos_pending_next;
    logic       stall;

    assign stall = stat.rd_valid && stat.chunk_end && !stat.out_free;

    assign in_ready        = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept      = in_valid && in_ready;
    assign cmd.issue       = (state_reg == S_COPY) && stat.copy_left_nz && !stall;
    assign cmd.consume     = (state_reg == S_COPY) && stat.rd_valid && !stall;
    assign cmd.status_load = (state_reg == S_STATUS) && stat.out_free;
    assign cmd.eos_pending = eos_pending_reg;

    assign eos_pending_next = cmd.accept ? end_of_stream : eos_pending_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (stat.copy_start)
                    begin
                        state_next = S_COPY;
                    end
                    else if (end_of_stream)
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_COPY:
            begin
                if (!stat.copy_left_nz && (!stat.rd_valid || !stall))
                begin
                    state_next = eos_pending_reg ? S_STATUS : S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            eos_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            eos_pending_reg <= eos_pending_next;
        end
    end

    `ASSERT_IMPLY(a_ready_only_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `ASSERT_IMPLY(a_issue_in_copy, clk, rst_n, cmd.issue, (state_reg == S_COPY) && stat.copy_left_nz)
    `ASSERT_NEXT(a_copy_entry, clk, rst_n, cmd.accept && stat.copy_start, state_reg == S_COPY)

endmodule

`default_nettype wire

FILE: design/lzf_datapath.sv
// Datapath of the LZF decompressor: token state, history store, packing, result register.
`default_nettype none
`include "assert_macros.svh"

module lzf_datapath #(
    parameter int HISTORY_BYTES    = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         in_byte,
    input  wire logic               end_of_stream,
    input  wire logic               out_ready,
    input  wire logic [31:0]        output_limit,
    input  wire lzf_pkg::lzf_cmd_t  cmd,
    output lzf_pkg::lzf_stat_t      stat,
    output logic                    out_valid,
    output logic [63:0]             out_word,
    output logic [3:0]              out_count,
    output logic                    run_last,
    output logic                    stream_done,
    output logic [1:0]              status,
    output logic [31:0]             total_length
);

    localparam int AW = $clog2(HISTORY_BYTES);

    logic [1:0]    phase_reg;
    logic [5:0]    literal_left_reg;
    logic [8:0]    copy_length_reg;
    logic [4:0]    offset_high_reg;
    logic [31:0]   produced_reg;
    logic [1:0]    error_reg;
    logic [8:0]    copy_left_reg;
    logic [AW-1:0] src_reg;
    logic          rd_valid_reg;
    logic [7:0]    rd_data_reg;
    logic [63:0]   pack_word_reg;
    logic [3:0]    pack_cnt_reg;
    logic          out_valid_reg;
    logic [63:0]   out_word_reg;
    logic [3:0]    out_count_reg;
    logic          out_last_reg;
    logic          out_done_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_total_reg;

    logic [7:0]    hist_mem [HISTORY_BYTES];

    logic          stream_ok;
    logic [5:0]    lit_len;
    logic          lit_over;
    logic          copy_over;
    logic [13:0]   offset;
    logic          ref_fail;
    logic          copy_start;
    logic          lit_emit;
    logic          chunk_end;
    logic          chunk_load;
    logic          out_free;
    logic [31:0]   src_diff;
    logic [63:0]   merged_word;
    logic [1:0]    close_status;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [31:0]   produced_inc;

    assign stream_ok = (error_reg == lzf_pkg::STAT_OK);
    assign lit_len   = 6'(in_byte[4:0]) + 6'd1;
    assign lit_over  = ({1'b0, produced_reg} + 33'(lit_len)) > {1'b0, output_limit};
    assign copy_over = ({1'b0, produced_reg} + 33'(copy_length_reg)) > {1'b0, output_limit};
    assign offset    = 14'({offset_high_reg, in_byte}) + 14'd1;
    assign ref_fail  = 32'(offset) > produced_reg;
    assign src_diff  = produced_reg - 32'(offset);
    assign produced_inc = produced_reg + 32'd1;

    assign copy_start = stream_ok && (phase_reg == lzf_pkg::PH_OFF) && !copy_over && !ref_fail;
    assign lit_emit   = cmd.accept && stream_ok && (phase_reg == lzf_pkg::PH_LIT);
    assign chunk_end  = (pack_cnt_reg == 4'(BYTES_PER_RESULT - 1)) || (copy_left_reg == '0);
    assign chunk_load = cmd.consume && chunk_end;
    assign out_free   = !out_valid_reg || out_ready;

    assign close_status = !stream_ok ? error_reg :
                          (phase_reg != lzf_pkg::PH_CTRL) ? lzf_pkg::STAT_TRUNCATED :
                          lzf_pkg::STAT_OK;

    assign stat.copy_start   = copy_start;
    assign stat.rd_valid     = rd_valid_reg;
    assign stat.copy_left_nz = (copy_left_reg != '0);
    assign stat.chunk_end    = chunk_end;
    assign stat.out_free     = out_free;

    always_comb
    begin
        merged_word = pack_word_reg;
        merged_word[{pack_cnt_reg[2:0], 3'b000} +: 8] = rd_data_reg;
    end

    assign wr_en   = lit_emit || cmd.consume;
    assign wr_addr = produced_reg[AW-1:0];
    assign wr_data = lit_emit ? in_byte : rd_data_reg;

    // History store with write-to-read forwarding for distance-one copies.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= (wr_en && (wr_addr == src_reg)) ? wr_data : hist_mem[src_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lzf_pkg::PH_CTRL;
            literal_left_reg <= '0;
            copy_length_reg  <= '0;
            offset_high_reg  <= '0;
            error_reg        <= lzf_pkg::STAT_OK;
        end
        else if (cmd.status_load)
        begin
            phase_reg        <= lzf_pkg::PH_CTRL;
            literal_left_reg <= '0;
            copy_length_reg  <= '0;
            offset_high_reg  <= '0;
            error_reg        <= lzf_pkg::STAT_OK;
        end
        else if (cmd.accept && stream_ok)
        begin
            unique case (phase_reg)
                lzf_pkg::PH_CTRL:
                begin
                    if (in_byte < lzf_pkg::LIT_CTRL_LIMIT)
                    begin
                        if (lit_over)
                        begin
                            error_reg <= lzf_pkg::STAT_LIMIT;
                        end
                        else
                        begin
                            literal_left_reg <= lit_len;
                            phase_reg        <= lzf_pkg::PH_LIT;
                        end
                    end
                    else
                    begin
                        copy_length_reg <= 9'(in_byte[7:5]) + lzf_pkg::LEN_BIAS;
                        offset_high_reg <= in_byte[4:0];
                        phase_reg       <= (in_byte[7:5] == lzf_pkg::LONG_LEN_CODE) ?
                                           lzf_pkg::PH_LEN : lzf_pkg::PH_OFF;
                    end
                end
                lzf_pkg::PH_LIT:
                begin
                    literal_left_reg <= literal_left_reg - 6'd1;
                    if (literal_left_reg == 6'd1)
                    begin
                        phase_reg <= lzf_pkg::PH_CTRL;
                    end
                end
                lzf_pkg::PH_LEN:
                begin
                    copy_length_reg <= lzf_pkg::LONG_LEN_BASE + 9'(in_byte);
                    phase_reg       <= lzf_pkg::PH_OFF;
                end
                lzf_pkg::PH_OFF:
                begin
                    phase_reg <= lzf_pkg::PH_CTRL;
                    if (copy_over)
                    begin
                        error_reg <= lzf_pkg::STAT_LIMIT;
                    end
                    else if (ref_fail)
                    begin
                        error_reg <= lzf_pkg::STAT_BEFORE_START;
                    end
                end
                default:
                begin
                    phase_reg <= lzf_pkg::PH_CTRL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            produced_reg <= '0;
        end
        else if (cmd.status_load)
        begin
            produced_reg <= '0;
        end
        else if (wr_en)
        begin
            produced_reg <= produced_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_left_reg <= '0;
            rd_valid_reg  <= 1'b0;
            pack_word_reg <= '0;
            pack_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.accept && copy_start)
            begin
                copy_left_reg <= copy_length_reg;
            end
            else if (cmd.issue)
            begin
                copy_left_reg <= copy_left_reg - 9'd1;
            end

            if (cmd.issue)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (cmd.consume)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (cmd.consume)
            begin
                if (chunk_end)
                begin
                    pack_word_reg <= '0;
                    pack_cnt_reg  <= '0;
                end
                else
                begin
                    pack_word_reg <= merged_word;
                    pack_cnt_reg  <= pack_cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && copy_start)
        begin
            src_reg <= src_diff[AW-1:0];
        end
        else if (cmd.issue)
        begin
            src_reg <= src_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (lit_emit || chunk_load || cmd.status_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lit_emit)
        begin
            out_word_reg   <= 64'(in_byte);
            out_count_reg  <= 4'd1;
            out_last_reg   <= !end_of_stream;
            out_done_reg   <= 1'b0;
            out_status_reg <= lzf_pkg::STAT_OK;
            out_total_reg  <= produced_inc;
        end
        else if (chunk_load)
        begin
            out_word_reg   <= merged_word;
            out_count_reg  <= pack_cnt_reg + 4'd1;
            out_last_reg   <= (copy_left_reg == '0) && !cmd.eos_pending;
            out_done_reg   <= 1'b0;
            out_status_reg <= lzf_pkg::STAT_OK;
            out_total_reg  <= produced_inc;
        end
        else if (cmd.status_load)
        begin
            out_word_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_done_reg   <= 1'b1;
            out_status_reg <= close_status;
            out_total_reg  <= produced_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;
    assign out_count    = out_count_reg;
    assign run_last     = out_last_reg;
    assign stream_done  = out_done_reg;
    assign status       = out_status_reg;
    assign total_length = out_total_reg;

    `ASSERT_NEXT(a_read_hold, clk, rst_n, rd_valid_reg && !cmd.consume && !cmd.issue, $stable(rd_data_reg))
    `ASSERT_IMPLY(a_done_status_only, clk, rst_n, out_valid_reg && out_done_reg, (out_count_reg == '0) && out_last_reg)
    `ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid_reg, out_count_reg <= 4'(BYTES_PER_RESULT))

endmodule

`default_nettype wire

FILE: design/lzf_stream_decompressor.sv
// Top level of the LZF stream decompressor with its APB register port.
// Literal byte: one request per cycle while output is free; result registered on accept.
// Back reference of L bytes: one byte per cycle from the history store read port.
// End of stream adds a closing status item; output stalls hold the copy.
// rst_n clears control state and sets output_limit to all ones; history is not cleared.
`default_nettype none

module lzf_stream_decompressor #(
    parameter int HISTORY_BYTES    = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lzf_byte_if.sink                              compressed,
    lzf_word_if.source                            decoded,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lzf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic               [31:0] output_limit_reg;
    logic                      limit_sel;
    lzf_pkg::lzf_cmd_t         cmd;
    lzf_pkg::lzf_stat_t        stat;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[2:2] == lzf_pkg::REG_OUTPUT_LIMIT);
    assign prdata    = limit_sel ? output_limit_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_limit_reg <= lzf_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_sel)
        begin
            output_limit_reg <= pwdata;
        end
    end

    lzf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (compressed.valid),
        .end_of_stream (compressed.end_of_stream),
        .in_ready      (compressed.ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lzf_datapath #(
        .HISTORY_BYTES    (HISTORY_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (compressed.in_byte),
        .end_of_stream (compressed.end_of_stream),
        .out_ready     (decoded.ready),
        .output_limit  (output_limit_reg),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (decoded.valid),
        .out_word      (decoded.out_word),
        .out_count     (decoded.out_count),
        .run_last      (decoded.run_last),
        .stream_done   (decoded.stream_done),
        .status        (decoded.status),
        .total_length  (decoded.total_length)
    );

endmodule

`default_nettype wire
